@@ src/cfpd_pkg.sv @@
// Shared constants and arithmetic helpers for the contact force PD step block.
// Used by contact_force_pd_step; depends on nothing else.
package cfpd_pkg;

  localparam int MulW   = 32;
  localparam int ProdW  = 80;
  localparam int DivW   = 55;
  localparam int DtW    = 20;
  localparam int StepW  = 57;
  localparam int SumW   = 67;

  localparam logic [31:0] RateScale = 32'd1000000;
  localparam logic [30:0] StepCap   = 31'h4000_0000;

  localparam logic signed [31:0] TargetRst = 32'sd196608;
  localparam logic [15:0] SmoothRst = 16'd58982;
  localparam logic [31:0] GainPRst  = 32'd1099511628;
  localparam logic [31:0] GainDRst  = 32'd109951163;
  localparam logic [31:0] GainRRst  = 32'd1099511628;
  localparam logic [30:0] MaxDRst   = 31'd536871;
  localparam logic [30:0] MaxTRst   = 31'd1073742;

  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_SMOOTH = 3'd1;
  localparam logic [2:0] REG_GAIN_P = 3'd2;
  localparam logic [2:0] REG_GAIN_D = 3'd3;
  localparam logic [2:0] REG_ROLL   = 3'd4;
  localparam logic [2:0] REG_PITCH  = 3'd5;
  localparam logic [2:0] REG_MAX_D  = 3'd6;
  localparam logic [2:0] REG_MAX_T  = 3'd7;

  typedef struct packed {
    logic [31:0] val;
    logic        flag;
  } clamp_t;

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    logic [47:0] r;
    r = v[47] ? 48'(-v) : 48'(v);
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [56:0] x);
    logic signed [47:0] r;
    if (x > 57'sh0_7FFF_FFFF_FFFF) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (x < -57'sh0_8000_0000_0000) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = x[47:0];
    end
    return r;
  endfunction

  function automatic clamp_t clamp_step(input logic signed [56:0] x, input logic [30:0] lim_reg);
    logic signed [56:0] lim;
    clamp_t r;
    lim = (lim_reg > StepCap) ? 57'(StepCap) : 57'(lim_reg);
    r.flag = 1'b0;
    r.val  = x[31:0];
    if (x > lim) begin
      r.flag = 1'b1;
      r.val  = lim[31:0];
    end else if (x < -lim) begin
      r.flag = 1'b1;
      r.val  = 32'(-lim);
    end
    return r;
  endfunction

endpackage

@@ src/contact_force_pd_step.sv @@
// Contact force PD step: bit-serial multiplier and divider under one sequencer.
// Depends on cfpd_pkg for constants, the clamp and the saturation helpers.
//
// Usage: a sample (force x, y, z and the interval in microseconds) enters on the
// in_ channel. The block forms the normal force error, its rate over the interval,
// a low-pass filtered rate and then a clamped depth step, roll and pitch steps and
// the saturating depth offset. The result leaves on the out_ channel as one
// transaction. A sample with a zero interval produces no result and only latches
// the first error after reset. Registers must be written on the cfg_ channel
// only while the block is idle, which the block does not enforce; cfg_ready is
// always high. One sample takes 7 serial multiplies on the single shift-add
// multiplier (one multiplier bit per cycle), a restoring divide on the
// one-bit-per-cycle divider and 8 steps between them. A new sample is accepted
// only while idle, after the result of the last one has gone into the output
// register. A zero-interval sample leaves the block idle.
// Reset restores the register defaults, clears the filter, the offset and the
// last error, and marks the next sample as the first one. When the receiver
// stalls, the finished result is held in the output register; the next sample
// is accepted and computed, and waits at the end until the output is free.
module contact_force_pd_step
  import cfpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // force_x[31:0], force_y[63:32], force_z[95:64], interval_us[115:96], zero pad
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // depth_step[31:0], roll_step[63:32], pitch_step[95:64], depth_offset[143:96],
  // depth_clamped[144], roll_clamped[145], pitch_clamped[146], zero pad
  output logic [151:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_RATE  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_DIVDN = 4'd4;
  localparam logic [3:0] S_FA    = 4'd5;
  localparam logic [3:0] S_FB    = 4'd6;
  localparam logic [3:0] S_P     = 4'd7;
  localparam logic [3:0] S_D     = 4'd8;
  localparam logic [3:0] S_R     = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic signed [31:0] target_r;
  logic [15:0] smooth_r;
  logic [31:0] gain_p_r, gain_d_r, gain_roll_r, gain_pitch_r;
  logic [30:0] max_d_r, max_t_r;

  logic [3:0]  state_r, state_nxt, ret_r, ret_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [ProdW-1:0] mcand_r, mcand_nxt, prod_r, prod_nxt;
  logic [MulW-1:0]  mplier_r, mplier_nxt;
  logic        sgn_r, sgn_nxt;
  logic [DivW-1:0] div_r, div_nxt;
  logic [DtW-1:0]  rem_r, rem_nxt, dt_r, dt_nxt;
  logic signed [32:0] err_r, err_nxt, last_r, last_nxt;
  logic        first_r, first_nxt;
  logic signed [47:0] filt_r, filt_nxt, acc_r, acc_nxt, rate_r, rate_nxt;
  logic [31:0] fx_r, fx_nxt, fy_r, fy_nxt;
  logic signed [SumW-1:0] sum_r, sum_nxt;
  logic signed [StepW-1:0] dz_r, dz_nxt;
  clamp_t      dzc_r, dzc_nxt, roll_r, roll_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [151:0] out_data_r, out_data_nxt;

  logic signed [32:0] c_err, c_last;
  logic signed [33:0] c_diff;
  logic [DtW-1:0] c_dt;
  logic [DtW:0]   c_trial;
  logic           c_ge;
  logic signed [StepW-1:0] c_q, c_term;
  logic signed [SumW-1:0]  c_sum;
  clamp_t         c_clamp;
  logic [16:0]    c_beta;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;  cnt_nxt = cnt_r;
    mcand_nxt = mcand_r;  prod_nxt = prod_r; mplier_nxt = mplier_r; sgn_nxt = sgn_r;
    div_nxt = div_r;  rem_nxt = rem_r;  dt_nxt = dt_r;
    err_nxt = err_r;  last_nxt = last_r;  first_nxt = first_r;
    filt_nxt = filt_r;  acc_nxt = acc_r;  rate_nxt = rate_r;
    fx_nxt = fx_r;  fy_nxt = fy_r;  sum_nxt = sum_r;  dz_nxt = dz_r;
    dzc_nxt = dzc_r;  roll_nxt = roll_r;
    out_valid_nxt = out_valid_r;  out_data_nxt = out_data_r;
    c_err   = $signed({target_r[31], target_r}) -
              $signed({in_tdata[95], in_tdata[95:64]});
    c_last  = first_r ? c_err : last_r;
    c_diff  = $signed({c_err[32], c_err}) - $signed({c_last[32], c_last});
    c_dt    = in_tdata[115:96];
    c_trial = {rem_r, div_r[DivW-1]};
    c_ge    = (c_trial >= {1'b0, dt_r});
    c_q     = sgn_r ? -$signed({2'b00, div_r}) : $signed({2'b00, div_r});
    c_term  = sgn_r ? -$signed({3'b000, prod_r[79:26]}) : $signed({3'b000, prod_r[79:26]});
    c_sum   = sgn_r ? -$signed({1'b0, prod_r[65:0]}) : $signed({1'b0, prod_r[65:0]});
    c_clamp = clamp_step(c_term, max_t_r);
    c_beta  = 17'h10000 - {1'b0, smooth_r};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          first_nxt = 1'b0;
          last_nxt  = c_last;
          err_nxt   = c_err;
          fx_nxt    = in_tdata[31:0];
          fy_nxt    = in_tdata[63:32];
          dt_nxt    = c_dt;
          if (c_dt != '0) begin
            mcand_nxt  = {32'b0, mag48(48'(c_diff))};
            mplier_nxt = RateScale;
            prod_nxt   = '0;
            cnt_nxt    = 6'(MulW);
            sgn_nxt    = c_diff[33];
            ret_nxt    = S_RATE;
            state_nxt  = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mplier_r[0]) begin
          prod_nxt = prod_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[ProdW-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[MulW-1:1]};
        cnt_nxt    = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          state_nxt = ret_r;
        end
      end
      S_RATE: begin
        div_nxt   = prod_r[DivW-1:0];
        rem_nxt   = '0;
        cnt_nxt   = 6'(DivW);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = c_ge ? DtW'(c_trial - {1'b0, dt_r}) : c_trial[DtW-1:0];
        div_nxt = {div_r[DivW-2:0], c_ge};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          state_nxt = S_DIVDN;
        end
      end
      S_DIVDN: begin
        rate_nxt   = sat48(c_q);
        mcand_nxt  = {32'b0, mag48(filt_r)};
        mplier_nxt = {16'b0, smooth_r};
        prod_nxt   = '0;
        cnt_nxt    = 6'(MulW);
        sgn_nxt    = filt_r[47];
        ret_nxt    = S_FA;
        state_nxt  = S_MUL;
      end
      S_FA: begin
        sum_nxt    = c_sum;
        mcand_nxt  = {32'b0, mag48(rate_r)};
        mplier_nxt = {15'b0, c_beta};
        prod_nxt   = '0;
        cnt_nxt    = 6'(MulW);
        sgn_nxt    = rate_r[47];
        ret_nxt    = S_FB;
        state_nxt  = S_MUL;
      end
      S_FB: begin
        filt_nxt   = 48'((sum_r + c_sum) >>> 16);
        last_nxt   = err_r;
        mcand_nxt  = {32'b0, mag48(48'(err_r))};
        mplier_nxt = gain_p_r;
        prod_nxt   = '0;
        cnt_nxt    = 6'(MulW);
        sgn_nxt    = err_r[32];
        ret_nxt    = S_P;
        state_nxt  = S_MUL;
      end
      S_P: begin
        dz_nxt     = c_term;
        mcand_nxt  = {32'b0, mag48(filt_r)};
        mplier_nxt = gain_d_r;
        prod_nxt   = '0;
        cnt_nxt    = 6'(MulW);
        sgn_nxt    = filt_r[47];
        ret_nxt    = S_D;
        state_nxt  = S_MUL;
      end
      S_D: begin
        dz_nxt     = dz_r + c_term;
        mcand_nxt  = {32'b0, mag48(48'($signed(fx_r)))};
        mplier_nxt = gain_roll_r;
        prod_nxt   = '0;
        cnt_nxt    = 6'(MulW);
        sgn_nxt    = fx_r[31];
        ret_nxt    = S_R;
        state_nxt  = S_MUL;
      end
      S_R: begin
        dzc_nxt    = clamp_step(dz_r, max_d_r);
        acc_nxt    = sat48(57'(acc_r) + 57'($signed(dzc_nxt.val)));
        roll_nxt   = c_clamp;
        mcand_nxt  = {32'b0, mag48(48'($signed(fy_r)))};
        mplier_nxt = gain_pitch_r;
        prod_nxt   = '0;
        cnt_nxt    = 6'(MulW);
        sgn_nxt    = (fy_r != '0) && !fy_r[31];
        ret_nxt    = S_EMIT;
        state_nxt  = S_MUL;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, c_clamp.flag, roll_r.flag, dzc_r.flag, acc_r,
                           c_clamp.val, roll_r.val, dzc_r.val};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;  cnt_r <= '0;  first_r <= 1'b1;  out_valid_r <= 1'b0;
      last_r <= '0;  filt_r <= '0;  acc_r <= '0;
      target_r <= TargetRst;  smooth_r <= SmoothRst;
      gain_p_r <= GainPRst;  gain_d_r <= GainDRst;
      gain_roll_r <= GainRRst;  gain_pitch_r <= GainRRst;
      max_d_r <= MaxDRst;  max_t_r <= MaxTRst;
    end else begin
      state_r <= state_nxt;  cnt_r <= cnt_nxt;  first_r <= first_nxt;
      out_valid_r <= out_valid_nxt;
      last_r <= last_nxt;  filt_r <= filt_nxt;  acc_r <= acc_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_TARGET: target_r     <= cfg_data;
          REG_SMOOTH: smooth_r     <= cfg_data[15:0];
          REG_GAIN_P: gain_p_r     <= cfg_data;
          REG_GAIN_D: gain_d_r     <= cfg_data;
          REG_ROLL:   gain_roll_r  <= cfg_data;
          REG_PITCH:  gain_pitch_r <= cfg_data;
          REG_MAX_D:  max_d_r      <= cfg_data[30:0];
          REG_MAX_T:  max_t_r      <= cfg_data[30:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;  mcand_r <= mcand_nxt;  prod_r <= prod_nxt;
    mplier_r <= mplier_nxt;  sgn_r <= sgn_nxt;  div_r <= div_nxt;
    rem_r <= rem_nxt;  dt_r <= dt_nxt;  err_r <= err_nxt;  rate_r <= rate_nxt;
    fx_r <= fx_nxt;  fy_r <= fy_nxt;  sum_r <= sum_nxt;  dz_r <= dz_nxt;
    dzc_r <= dzc_nxt;  roll_r <= roll_nxt;  out_data_r <= out_data_nxt;
  end

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_DIV) |-> (cnt_r != '0))
    else $error("serial counter ran out inside an iteration");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < dt_r))
    else $error("divider remainder not below the interval");

  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata[115:96] == '0)) |=> (state_r == S_IDLE))
    else $error("zero interval sample started a computation");

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && state_r == S_EMIT) |=> (state_r == S_EMIT))
    else $error("result left the sequencer while the output was full");

endmodule

@@ bench/tb_contact_force_pd_step.sv @@
// Testbench for contact_force_pd_step: random and directed force samples with register changes.
// Depends on cfpd_pkg and the block; a scoreboard class predicts each result and checks it.
`timescale 1ns / 100ps

class pd_scoreboard;
  longint target;
  longint alpha;
  longint kp, kd, kr, kpt;
  longint max_d, max_t;
  longint prev_err, filt_rate, offset;
  bit first_pending;
  logic [151:0] pending_q[$];
  int errors;

  function new();
    errors = 0;
    reset_state();
  endfunction

  function void reset_state();
    target = 196608; alpha = 58982;
    kp = 1099511628; kd = 109951163; kr = 1099511628; kpt = 1099511628;
    max_d = 536871; max_t = 1073742;
    prev_err = 0; filt_rate = 0; offset = 0; first_pending = 1;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      cfpd_pkg::REG_TARGET: target = longint'($signed(v));
      cfpd_pkg::REG_SMOOTH: alpha = longint'(v[15:0]);
      cfpd_pkg::REG_GAIN_P: kp = longint'(v);
      cfpd_pkg::REG_GAIN_D: kd = longint'(v);
      cfpd_pkg::REG_ROLL:   kr = longint'(v);
      cfpd_pkg::REG_PITCH:  kpt = longint'(v);
      cfpd_pkg::REG_MAX_D:  max_d = longint'(v[30:0]);
      cfpd_pkg::REG_MAX_T:  max_t = longint'(v[30:0]);
      default: ;
    endcase
  endfunction

  function longint sat(longint x);
    if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return x;
  endfunction

  function longint scaled(longint g, longint v);
    logic [127:0] p;
    longint m;
    m = (v < 0) ? -v : v;
    p = (128'(g) * 128'(m)) >> 26;
    return (v < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function longint limit(longint x, longint lim_reg, output bit flag);
    longint lim;
    lim = (lim_reg > (64'sd1 << 30)) ? (64'sd1 << 30) : lim_reg;
    flag = 0;
    if (x > lim) begin flag = 1; return lim; end
    if (x < -lim) begin flag = 1; return -lim; end
    return x;
  endfunction

  function void note_sample(logic [119:0] d);
    longint fx, fy, fz, dt, err, rate, dz, dr, dp;
    logic signed [127:0] mix;
    bit fd, fr, fp;
    fx = longint'($signed(d[31:0]));
    fy = longint'($signed(d[63:32]));
    fz = longint'($signed(d[95:64]));
    dt = longint'(d[115:96]);
    err = target - fz;
    if (first_pending) begin
      prev_err = err; first_pending = 0;
    end
    if (dt == 0) return;
    rate = sat(((err - prev_err) * 1000000) / dt);
    mix = 128'(alpha) * 128'(filt_rate) + 128'(65536 - alpha) * 128'(rate);
    filt_rate = longint'(mix >>> 16);
    prev_err = err;
    dz = limit(scaled(kp, err) + scaled(kd, filt_rate), max_d, fd);
    dr = limit(scaled(kr, fx), max_t, fr);
    dp = limit(scaled(kpt, -fy), max_t, fp);
    offset = sat(offset + dz);
    pending_q.push_back({5'd0, fp, fr, fd, offset[47:0], dp[31:0], dr[31:0], dz[31:0]});
  endfunction

  function void check_result(logic [151:0] got);
    logic [151:0] e;
    if (pending_q.size() == 0) begin
      $error("result with no expectation: %h", got);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (got[31:0] !== e[31:0]) begin
      $error("depth_step exp %h got %h", e[31:0], got[31:0]); errors++;
    end
    if (got[63:32] !== e[63:32]) begin
      $error("roll_step exp %h got %h", e[63:32], got[63:32]); errors++;
    end
    if (got[95:64] !== e[95:64]) begin
      $error("pitch_step exp %h got %h", e[95:64], got[95:64]); errors++;
    end
    if (got[143:96] !== e[143:96]) begin
      $error("depth_offset exp %h got %h", e[143:96], got[143:96]); errors++;
    end
    if (got[144] !== e[144]) begin
      $error("depth_clamped exp %b got %b", e[144], got[144]); errors++;
    end
    if (got[145] !== e[145]) begin
      $error("roll_clamped exp %b got %b", e[145], got[145]); errors++;
    end
    if (got[146] !== e[146]) begin
      $error("pitch_clamped exp %b got %b", e[146], got[146]); errors++;
    end
  endfunction
endclass

module tb_contact_force_pd_step;
  import cfpd_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [119:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [151:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pd_scoreboard board = new();
  bit calm = 0;
  bit hold_off = 0;

  contact_force_pd_step uut (.*);

  always #4 clk = ~clk;

  initial begin
    #50ms;
    $display("tb_contact_force_pd_step: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  initial begin : sink
    int n;
    wait (rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 0;
        repeat (1500) @(posedge clk);
        hold_off = 0;
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz, logic [19:0] dt);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 13);
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {4'd0, dt, fz, fy, fx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_sample({4'd0, dt, fz, fy, fx});
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_force();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
    endcase
  endfunction

  function automatic logic [19:0] rand_dt();
    case ($urandom_range(0, 9))
      0: return 20'd0;
      1: return $urandom_range(0, 1) ? 20'd1 : 20'd1000000;
      2: return 20'($urandom_range(1, 1000000));
      3: return 20'(~$urandom_range(0, 0));
      default: return 20'($urandom_range(5000, 20000));
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      send(rand_force(), rand_force(), rand_force(), rand_dt());
    end
  endtask

  initial begin : stim
    logic [31:0] settings[8];
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // First sample with zero interval only latches the error.
    send(32'd0, 32'd0, 32'd65536, 20'd0);
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 20'd1);
    send(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'd1);
    send(32'd0, 32'd0, 32'd0, 20'd1000000);
    send(32'hFFFF_FFFF, 32'd1, 32'h0003_0000, 20'hFFFFF);
    send(32'd65536, 32'hFFFF_0000, 32'h0002_0000, 20'd10000);
    send(32'd0, 32'd0, 32'd0, 20'd0);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20'd1);
    for (int i = 0; i < 8; i++) send(rand_force(), rand_force(), 32'h8000_0000, 20'd1);
    drain();
    random_phase(150);
    drain();
    // Extremes: large clamps, zero clamps, full gains and filter weights.
    write_reg(REG_MAX_D, 32'h7FFF_FFFF);
    write_reg(REG_MAX_T, 32'h4000_0000);
    write_reg(REG_GAIN_P, 32'hFFFF_FFFF);
    write_reg(REG_GAIN_D, 32'hFFFF_FFFF);
    write_reg(REG_ROLL, 32'hFFFF_FFFF);
    write_reg(REG_PITCH, 32'd0);
    write_reg(REG_SMOOTH, 32'd0);
    write_reg(REG_TARGET, 32'h7FFF_FFFF);
    random_phase(120);
    drain();
    write_reg(REG_MAX_D, 32'd0);
    write_reg(REG_MAX_T, 32'd0);
    write_reg(REG_SMOOTH, 32'hFFFF);
    write_reg(REG_TARGET, 32'h8000_0000);
    write_reg(REG_GAIN_P, 32'd0);
    write_reg(REG_PITCH, 32'hFFFF_FFFF);
    random_phase(100);
    drain();
    // Receiver holds off while samples keep coming.
    hold_off = 1;
    random_phase(40);
    drain();
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 8; r++) settings[r] = $urandom();
      settings[REG_MAX_D] = $urandom_range(0, 1 << 22);
      settings[REG_MAX_T] = $urandom_range(0, 1 << 22);
      for (int r = 0; r < 8; r++) write_reg(3'(r), settings[r]);
      random_phase(110);
      drain();
    end
    calm = 1;
    random_phase(60);
    drain();
    if (board.errors == 0) begin
      $display("tb_contact_force_pd_step: PASS");
    end else begin
      $display("tb_contact_force_pd_step: FAIL");
    end
    $finish;
  end
endmodule

@@ contact_force_pd_step.f @@
src/cfpd_pkg.sv
src/contact_force_pd_step.sv
bench/tb_contact_force_pd_step.sv
